>>> rtl/core/canmfd_pkg.sv
// canmfd_pkg: shared types and constants of the CAN message frame decoder
// status and kind codes, register indexes, config and message structs
// no dependencies
package canmfd_pkg;

   localparam int TEXT_MAX_LEN      = 3;
   localparam int TEXT_HEADER_BYTES = 5;
   localparam int FULL_FRAME_BYTES  = 8;
   localparam int CSR_ADDR_W        = 5;
   localparam int CSR_DATA_W        = 32;
   localparam logic [7:0] CHAR_LOW  = 8'd32;
   localparam logic [7:0] CHAR_HIGH = 8'd126;

   // status codes
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_INVALID     = 2'd1;
   localparam logic [1:0] ST_IGNORED     = 2'd2;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

   // message kinds, also used as payload class
   localparam logic [1:0] KIND_COMMAND  = 2'd0;
   localparam logic [1:0] KIND_RESPONSE = 2'd1;
   localparam logic [1:0] KIND_EVENT    = 2'd2;
   localparam logic [1:0] KIND_TEXT     = 2'd3;

   // register indexes
   localparam logic [2:0] REG_PROTOCOL_VERSION = 3'd0;
   localparam logic [2:0] REG_NODE_ID_LOW      = 3'd1;
   localparam logic [2:0] REG_NODE_ID_HIGH     = 3'd2;
   localparam logic [2:0] REG_BROADCAST_NODE   = 3'd3;
   localparam logic [2:0] REG_COMMAND_STD_ID   = 3'd4;
   localparam logic [2:0] REG_RESPONSE_STD_ID  = 3'd5;
   localparam logic [2:0] REG_EVENT_STD_ID     = 3'd6;
   localparam logic [2:0] REG_TEXT_STD_ID      = 3'd7;

   typedef struct packed {
      logic [7:0]  protocol_version;
      logic [7:0]  node_id_low;
      logic [7:0]  node_id_high;
      logic [7:0]  broadcast_node;
      logic [10:0] command_std_id;
      logic [10:0] response_std_id;
      logic [10:0] event_std_id;
      logic [10:0] text_std_id;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  msg_kind;
      logic [7:0]  version;
      logic [7:0]  source_node;
      logic [7:0]  target_node;
      logic [7:0]  request_tag;
      logic [7:0]  text_kind;
      logic [1:0]  text_len;
      logic [1:0]  payload_class;
      logic [23:0] body_bytes;
      logic [7:0]  flag_byte;
   } msg_type;

endpackage

>>> rtl/core/canmfd_decode.sv
// canmfd_decode: combinational frame classification and field extraction
// turns one registered frame into a status code and message fields
// depends on canmfd_pkg
module canmfd_decode (
   input  logic                 is_extended,
   input  logic                 is_remote,
   input  logic [28:0]          frame_id,
   input  logic [3:0]           data_length,
   input  logic [63:0]          frame_bytes,
   input  canmfd_pkg::cfg_type  cfg,
   output logic [1:0]           status,
   output canmfd_pkg::msg_type  msg
);
   import canmfd_pkg::*;

   logic [7:0]  ver;
   logic [7:0]  src;
   logic [7:0]  dst;
   logic [7:0]  len;
   logic [1:0]  kind;
   logic        id_hit;
   logic        src_ok;
   logic        dst_ok;
   logic        hdr_ok;
   logic        text_ok;
   logic        full_ok;
   logic        chars_ok;
   logic [8:0]  text_end;
   logic [23:0] text_body;
   logic [7:0]  chr;

   assign ver = frame_bytes[7:0];
   assign src = frame_bytes[15:8];
   assign dst = frame_bytes[23:16];
   assign len = frame_bytes[39:32];

   // first match wins when identifiers coincide
   always_comb begin
      id_hit = 1'b1;
      kind   = KIND_COMMAND;
      if (frame_id == {18'd0, cfg.command_std_id}) begin
         kind = KIND_COMMAND;
      end else if (frame_id == {18'd0, cfg.response_std_id}) begin
         kind = KIND_RESPONSE;
      end else if (frame_id == {18'd0, cfg.event_std_id}) begin
         kind = KIND_EVENT;
      end else if (frame_id == {18'd0, cfg.text_std_id}) begin
         kind = KIND_TEXT;
      end else begin
         id_hit = 1'b0;
      end
   end

   assign src_ok = (src == cfg.broadcast_node) ||
                   (src >= cfg.node_id_low && src <= cfg.node_id_high);
   assign dst_ok = (dst == cfg.broadcast_node) ||
                   (dst >= cfg.node_id_low && dst <= cfg.node_id_high);
   assign hdr_ok = (ver == cfg.protocol_version) && src_ok && dst_ok;

   assign text_end = 9'(TEXT_HEADER_BYTES) + {1'b0, len};

   // characters past the length byte are neither checked nor kept
   always_comb begin
      chars_ok  = 1'b1;
      text_body = '0;
      chr       = '0;
      for (int i = 0; i < TEXT_MAX_LEN; i++) begin
         chr = frame_bytes[8*(TEXT_HEADER_BYTES+i) +: 8];
         if (8'(i) < len) begin
            text_body[8*i +: 8] = chr;
            if (chr < CHAR_LOW || chr > CHAR_HIGH) begin
               chars_ok = 1'b0;
            end
         end
      end
   end

   assign text_ok = (data_length >= 4'(TEXT_HEADER_BYTES)) && hdr_ok &&
                    (len != 8'd0) && (len <= 8'(TEXT_MAX_LEN)) &&
                    (text_end <= {5'd0, data_length}) && chars_ok;
   assign full_ok = (data_length >= 4'(FULL_FRAME_BYTES)) && hdr_ok;

   always_comb begin
      msg = '0;
      if (is_extended || is_remote) begin
         status = ST_UNSUPPORTED;
      end else if (!id_hit) begin
         status = ST_IGNORED;
      end else if (kind == KIND_TEXT) begin
         if (text_ok) begin
            status            = ST_OK;
            msg.msg_kind      = KIND_TEXT;
            msg.version       = ver;
            msg.source_node   = src;
            msg.target_node   = dst;
            msg.text_kind     = frame_bytes[31:24];
            msg.text_len      = len[1:0];
            msg.payload_class = KIND_TEXT;
            msg.body_bytes    = text_body;
         end else begin
            status = ST_INVALID;
         end
      end else if (full_ok) begin
         status            = ST_OK;
         msg.msg_kind      = kind;
         msg.version       = ver;
         msg.source_node   = src;
         msg.target_node   = dst;
         msg.request_tag   = frame_bytes[31:24];
         msg.payload_class = kind;
         msg.body_bytes    = frame_bytes[55:32];
         msg.flag_byte     = frame_bytes[63:56];
      end else begin
         status = ST_INVALID;
      end
   end

endmodule

>>> rtl/core/can_message_frame_decoder.sv
// can_message_frame_decoder: top level with request register, result register,
// status counters and configuration registers
// depends on canmfd_pkg and canmfd_decode
//
// Each request carries one received CAN frame and yields exactly one result.
// A new request is taken every cycle unless the result side stalls. The path
// between the request register and the result register holds the identifier
// match, the header and text checks and one 32-bit counter increment. Extended
// or remote frames are unsupported, unknown standard identifiers are ignored,
// and all message fields read zero on any status other than ok. The result
// carries the updated wrapping count of its status class. Registers sit at
// byte address 4*i; the user must write them only while no request is in
// flight, and the block itself does not enforce this.
module can_message_frame_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_is_extended,
   input  logic                                req_is_remote,
   input  logic [28:0]                         req_frame_id,
   input  logic [3:0]                          req_data_length,
   input  logic [63:0]                         req_frame_bytes,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [1:0]                          rsp_msg_kind,
   output logic [7:0]                          rsp_version,
   output logic [7:0]                          rsp_source_node,
   output logic [7:0]                          rsp_target_node,
   output logic [7:0]                          rsp_request_tag,
   output logic [7:0]                          rsp_text_kind,
   output logic [1:0]                          rsp_text_len,
   output logic [1:0]                          rsp_payload_class,
   output logic [23:0]                         rsp_body_bytes,
   output logic [7:0]                          rsp_flag_byte,
   output logic [31:0]                         rsp_status_count,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [canmfd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [canmfd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [canmfd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready
);
   import canmfd_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        csr_write;
   logic [2:0]  csr_index;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic        s1_extended_ff;
   logic        s1_remote_ff;
   logic [28:0] s1_frame_id_ff;
   logic [3:0]  s1_length_ff;
   logic [63:0] s1_bytes_ff;
   logic        s1_adv;
   logic        s2_adv;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   msg_type     rsp_msg_ff;
   logic [31:0] rsp_count_ff;

   logic [31:0] cnt_ff [4];
   logic [31:0] cnt_in;

   logic [1:0]  dec_status;
   msg_type     dec_msg;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PROTOCOL_VERSION: cfg_in.protocol_version = pwdata[7:0];
            REG_NODE_ID_LOW:      cfg_in.node_id_low      = pwdata[7:0];
            REG_NODE_ID_HIGH:     cfg_in.node_id_high     = pwdata[7:0];
            REG_BROADCAST_NODE:   cfg_in.broadcast_node   = pwdata[7:0];
            REG_COMMAND_STD_ID:   cfg_in.command_std_id   = pwdata[10:0];
            REG_RESPONSE_STD_ID:  cfg_in.response_std_id  = pwdata[10:0];
            REG_EVENT_STD_ID:     cfg_in.event_std_id     = pwdata[10:0];
            REG_TEXT_STD_ID:      cfg_in.text_std_id      = pwdata[10:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PROTOCOL_VERSION: prdata = {24'd0, cfg_ff.protocol_version};
         REG_NODE_ID_LOW:      prdata = {24'd0, cfg_ff.node_id_low};
         REG_NODE_ID_HIGH:     prdata = {24'd0, cfg_ff.node_id_high};
         REG_BROADCAST_NODE:   prdata = {24'd0, cfg_ff.broadcast_node};
         REG_COMMAND_STD_ID:   prdata = {21'd0, cfg_ff.command_std_id};
         REG_RESPONSE_STD_ID:  prdata = {21'd0, cfg_ff.response_std_id};
         REG_EVENT_STD_ID:     prdata = {21'd0, cfg_ff.event_std_id};
         REG_TEXT_STD_ID:      prdata = {21'd0, cfg_ff.text_std_id};
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.protocol_version <= 8'd1;
         cfg_ff.node_id_low      <= 8'd1;
         cfg_ff.node_id_high     <= 8'd254;
         cfg_ff.broadcast_node   <= 8'd255;
         cfg_ff.command_std_id   <= 11'd256;
         cfg_ff.response_std_id  <= 11'd257;
         cfg_ff.event_std_id     <= 11'd258;
         cfg_ff.text_std_id      <= 11'd259;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // two-stage pipeline, each stage moves on when the one after it has room
   assign s2_adv       = !rsp_valid_ff || !rsp_stall;
   assign s1_adv       = !s1_valid_ff || s2_adv;
   assign req_stall    = !s1_adv;
   assign s1_valid_in  = s1_adv ? req_valid : s1_valid_ff;
   assign rsp_valid_in = s2_adv ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && req_valid) begin
         s1_extended_ff <= req_is_extended;
         s1_remote_ff   <= req_is_remote;
         s1_frame_id_ff <= req_frame_id;
         s1_length_ff   <= req_data_length;
         s1_bytes_ff    <= req_frame_bytes;
      end
   end

   canmfd_decode u_decode (
      .is_extended (s1_extended_ff),
      .is_remote   (s1_remote_ff),
      .frame_id    (s1_frame_id_ff),
      .data_length (s1_length_ff),
      .frame_bytes (s1_bytes_ff),
      .cfg         (cfg_ff),
      .status      (dec_status),
      .msg         (dec_msg)
   );

   assign cnt_in = cnt_ff[dec_status] + 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (s2_adv && s1_valid_ff) begin
         cnt_ff[dec_status] <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s1_valid_ff) begin
         rsp_status_ff <= dec_status;
         rsp_msg_ff    <= dec_msg;
         rsp_count_ff  <= cnt_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_msg_kind      = rsp_msg_ff.msg_kind;
   assign rsp_version       = rsp_msg_ff.version;
   assign rsp_source_node   = rsp_msg_ff.source_node;
   assign rsp_target_node   = rsp_msg_ff.target_node;
   assign rsp_request_tag   = rsp_msg_ff.request_tag;
   assign rsp_text_kind     = rsp_msg_ff.text_kind;
   assign rsp_text_len      = rsp_msg_ff.text_len;
   assign rsp_payload_class = rsp_msg_ff.payload_class;
   assign rsp_body_bytes    = rsp_msg_ff.body_bytes;
   assign rsp_flag_byte     = rsp_msg_ff.flag_byte;
   assign rsp_status_count  = rsp_count_ff;

   // the pipeline only holds back when both stages are full and the output waits
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled while the pipeline had room");

   // an accepted request always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted request lost");

   // a waiting result shows the live count of its status class
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == cnt_ff[rsp_status_ff]))
      else $error("result count out of step with counter");

   // message fields are blank on any non-ok status
   a_blank_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_msg_ff == '0))
      else $error("message fields set on non-ok status");

   // an ok text result has a legal character count
   a_text_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_OK && rsp_msg_ff.msg_kind == KIND_TEXT)
      |-> (rsp_msg_ff.text_len != 2'd0 && rsp_msg_ff.payload_class == KIND_TEXT))
      else $error("text result with bad length or class");

endmodule

>>> verif/tb_can_message_frame_decoder.sv
// tb_can_message_frame_decoder: self-checking testbench of the CAN message frame decoder
// drives frames and register writes, predicts every decoded message and compares it
// depends on canmfd_pkg and can_message_frame_decoder
`timescale 1ns / 1ps

module tb_can_message_frame_decoder;
   import canmfd_pkg::*;

   localparam int NUM_PHASES       = 8;
   localparam int RANDOM_PER_PHASE = 160;
   localparam int CYCLE_LIMIT      = 400000;

   typedef struct packed {
      logic        is_extended;
      logic        is_remote;
      logic [28:0] frame_id;
      logic [3:0]  data_length;
      logic [63:0] frame_bytes;
   } can_frame_type;

   typedef struct packed {
      logic [1:0]  status;
      msg_type     msg;
      logic [31:0] status_count;
   } decoded_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_is_extended = 1'b0;
   logic        req_is_remote   = 1'b0;
   logic [28:0] req_frame_id    = '0;
   logic [3:0]  req_data_length = '0;
   logic [63:0] req_frame_bytes = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_msg_kind;
   logic [7:0]  rsp_version;
   logic [7:0]  rsp_source_node;
   logic [7:0]  rsp_target_node;
   logic [7:0]  rsp_request_tag;
   logic [7:0]  rsp_text_kind;
   logic [1:0]  rsp_text_len;
   logic [1:0]  rsp_payload_class;
   logic [23:0] rsp_body_bytes;
   logic [7:0]  rsp_flag_byte;
   logic [31:0] rsp_status_count;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor state: register copy and the four status counters
   cfg_type     cfg;
   logic [31:0] status_tally [4];

   can_frame_type frames_to_send [$];
   decoded_type   expected_msgs [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int mismatches    = 0;
   int results_seen  = 0;
   int cycle_count   = 0;

   can_message_frame_decoder DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_is_extended   (req_is_extended),
      .req_is_remote     (req_is_remote),
      .req_frame_id      (req_frame_id),
      .req_data_length   (req_data_length),
      .req_frame_bytes   (req_frame_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_msg_kind      (rsp_msg_kind),
      .rsp_version       (rsp_version),
      .rsp_source_node   (rsp_source_node),
      .rsp_target_node   (rsp_target_node),
      .rsp_request_tag   (rsp_request_tag),
      .rsp_text_kind     (rsp_text_kind),
      .rsp_text_len      (rsp_text_len),
      .rsp_payload_class (rsp_payload_class),
      .rsp_body_bytes    (rsp_body_bytes),
      .rsp_flag_byte     (rsp_flag_byte),
      .rsp_status_count  (rsp_status_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic node_accepted(input logic [7:0] id);
      return id == cfg.broadcast_node || (id >= cfg.node_id_low && id <= cfg.node_id_high);
   endfunction

   // first match wins in the order command, response, event, text
   function automatic logic id_kind(input logic [28:0] id, output logic [1:0] kind);
      kind = KIND_COMMAND;
      if (id == {18'd0, cfg.command_std_id}) kind = KIND_COMMAND;
      else if (id == {18'd0, cfg.response_std_id}) kind = KIND_RESPONSE;
      else if (id == {18'd0, cfg.event_std_id}) kind = KIND_EVENT;
      else if (id == {18'd0, cfg.text_std_id}) kind = KIND_TEXT;
      else return 1'b0;
      return 1'b1;
   endfunction

   function automatic decoded_type decode_and_count(input can_frame_type f);
      decoded_type r;
      logic [7:0]  b [8];
      logic [1:0]  kind;
      logic [1:0]  st;
      r = '0;
      for (int i = 0; i < 8; i++) b[i] = f.frame_bytes[8*i +: 8];
      st = ST_OK;
      if (f.is_extended || f.is_remote) begin
         st = ST_UNSUPPORTED;
      end else if (!id_kind(f.frame_id, kind)) begin
         st = ST_IGNORED;
      end else if (kind == KIND_TEXT) begin
         if (int'(f.data_length) < TEXT_HEADER_BYTES) st = ST_INVALID;
         else if (b[0] != cfg.protocol_version) st = ST_INVALID;
         else if (!node_accepted(b[1]) || !node_accepted(b[2])) st = ST_INVALID;
         else if (b[4] == 0 || int'(b[4]) > TEXT_MAX_LEN) st = ST_INVALID;
         else if (TEXT_HEADER_BYTES + int'(b[4]) > int'(f.data_length)) st = ST_INVALID;
         else begin
            for (int i = 0; i < int'(b[4]); i++) begin
               if (b[TEXT_HEADER_BYTES+i] < CHAR_LOW || b[TEXT_HEADER_BYTES+i] > CHAR_HIGH)
                  st = ST_INVALID;
               r.msg.body_bytes[8*i +: 8] = b[TEXT_HEADER_BYTES+i];
            end
         end
         r.msg.text_kind = b[3];
         r.msg.text_len  = b[4][1:0];
      end else begin
         if (int'(f.data_length) < FULL_FRAME_BYTES) st = ST_INVALID;
         else if (b[0] != cfg.protocol_version) st = ST_INVALID;
         else if (!node_accepted(b[1]) || !node_accepted(b[2])) st = ST_INVALID;
         r.msg.request_tag = b[3];
         r.msg.body_bytes  = {b[6], b[5], b[4]};
         r.msg.flag_byte   = b[7];
      end
      r.msg.msg_kind      = kind;
      r.msg.payload_class = kind;
      r.msg.version       = b[0];
      r.msg.source_node   = b[1];
      r.msg.target_node   = b[2];
      if (st != ST_OK) r.msg = '0;
      status_tally[st] = status_tally[st] + 32'd1;
      r.status       = st;
      r.status_count = status_tally[st];
      return r;
   endfunction

   function automatic can_frame_type make_frame(input logic ext, input logic rem,
                                                input logic [28:0] id, input logic [3:0] dlc,
                                                input logic [63:0] data);
      can_frame_type f;
      f.is_extended = ext;
      f.is_remote   = rem;
      f.frame_id    = id;
      f.data_length = dlc;
      f.frame_bytes = data;
      return f;
   endfunction

   // plain standard data frame
   function automatic can_frame_type std_frame(input logic [28:0] id, input logic [3:0] dlc,
                                               input logic [63:0] data);
      return make_frame(1'b0, 1'b0, id, dlc, data);
   endfunction

   function automatic logic [7:0] pick_node();
      if ($urandom_range(9) == 0) return 8'($urandom);
      if ($urandom_range(3) == 0 || cfg.node_id_low > cfg.node_id_high)
         return cfg.broadcast_node;
      return 8'($urandom_range(cfg.node_id_high, cfg.node_id_low));
   endfunction

   // mostly well-formed frames for one of the configured identifiers
   function automatic can_frame_type random_frame();
      can_frame_type f;
      logic [7:0]    b [8];
      logic [1:0]    kind;
      int            sel;
      int            len;
      int            min_dlc;
      f.is_extended = ($urandom_range(19) == 0);
      f.is_remote   = ($urandom_range(19) == 0);
      sel = $urandom_range(19);
      if (sel < 4) f.frame_id = {18'd0, cfg.command_std_id};
      else if (sel < 8) f.frame_id = {18'd0, cfg.response_std_id};
      else if (sel < 12) f.frame_id = {18'd0, cfg.event_std_id};
      else if (sel < 17) f.frame_id = {18'd0, cfg.text_std_id};
      else if (sel == 17) f.frame_id = {18'd0, 11'($urandom)};
      else if (sel == 18) f.frame_id = 29'($urandom);
      else f.frame_id = {18'($urandom), cfg.text_std_id};
      for (int i = 0; i < 8; i++) b[i] = 8'($urandom);
      b[0] = ($urandom_range(9) == 0) ? 8'($urandom) : cfg.protocol_version;
      b[1] = pick_node();
      b[2] = pick_node();
      if (id_kind(f.frame_id, kind) && kind == KIND_TEXT) begin
         sel = $urandom_range(19);
         if (sel == 0) len = 0;
         else if (sel == 1) len = $urandom_range(255, TEXT_MAX_LEN + 1);
         else len = $urandom_range(TEXT_MAX_LEN, 1);
         b[4] = 8'(len);
         for (int i = 0; i < TEXT_MAX_LEN; i++)
            b[TEXT_HEADER_BYTES+i] = ($urandom_range(14) == 0) ? 8'($urandom)
                                     : 8'($urandom_range(CHAR_HIGH, CHAR_LOW));
         min_dlc = TEXT_HEADER_BYTES + ((len <= TEXT_MAX_LEN) ? len : 0);
      end else begin
         min_dlc = FULL_FRAME_BYTES;
      end
      f.data_length = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(15, min_dlc));
      f.frame_bytes = {b[7], b[6], b[5], b[4], b[3], b[2], b[1], b[0]};
      return f;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // write one register, then read it back
   task automatic csr_write(input logic [2:0] idx, input logic [10:0] value);
      logic [31:0] word;
      logic [31:0] want;
      word = $urandom;
      word[10:0] = value;
      case (idx)
         REG_PROTOCOL_VERSION: cfg.protocol_version = value[7:0];
         REG_NODE_ID_LOW:      cfg.node_id_low      = value[7:0];
         REG_NODE_ID_HIGH:     cfg.node_id_high     = value[7:0];
         REG_BROADCAST_NODE:   cfg.broadcast_node   = value[7:0];
         REG_COMMAND_STD_ID:   cfg.command_std_id   = value;
         REG_RESPONSE_STD_ID:  cfg.response_std_id  = value;
         REG_EVENT_STD_ID:     cfg.event_std_id     = value;
         REG_TEXT_STD_ID:      cfg.text_std_id      = value;
         default: ;
      endcase
      want = (idx < REG_COMMAND_STD_ID) ? {24'd0, value[7:0]} : {21'd0, value};
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // back-to-back read of the same register
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field($sformatf("register %0d readback", idx), want, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      do @(negedge clock);
      while (frames_to_send.size() != 0 || req_valid || expected_msgs.size() != 0);
      repeat (3) @(posedge clock);
      @(negedge clock);
   endtask

   // request driver: prediction is made when the DUT takes the request
   always @(posedge clock) begin : frame_driver
      can_frame_type next_frame;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_msgs.push_back(decode_and_count(make_frame(req_is_extended, req_is_remote,
                                       req_frame_id, req_data_length, req_frame_bytes)));
         if (!req_valid || !req_stall) begin
            if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_frame = frames_to_send.pop_front();
               req_valid       <= 1'b1;
               req_is_extended <= next_frame.is_extended;
               req_is_remote   <= next_frame.is_remote;
               req_frame_id    <= next_frame.frame_id;
               req_data_length <= next_frame.data_length;
               req_frame_bytes <= next_frame.frame_bytes;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : message_monitor
      decoded_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_msgs.size() == 0) begin
            $error("result with status %0d arrived with nothing outstanding", rsp_status);
            mismatches++;
         end else begin
            want = expected_msgs.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("msg_kind", 32'(want.msg.msg_kind), 32'(rsp_msg_kind));
            check_field("version", 32'(want.msg.version), 32'(rsp_version));
            check_field("source_node", 32'(want.msg.source_node), 32'(rsp_source_node));
            check_field("target_node", 32'(want.msg.target_node), 32'(rsp_target_node));
            check_field("request_tag", 32'(want.msg.request_tag), 32'(rsp_request_tag));
            check_field("text_kind", 32'(want.msg.text_kind), 32'(rsp_text_kind));
            check_field("text_len", 32'(want.msg.text_len), 32'(rsp_text_len));
            check_field("payload_class", 32'(want.msg.payload_class),
                        32'(rsp_payload_class));
            check_field("body_bytes", 32'(want.msg.body_bytes), 32'(rsp_body_bytes));
            check_field("flag_byte", 32'(want.msg.flag_byte), 32'(rsp_flag_byte));
            check_field("status_count", want.status_count, rsp_status_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_msgs.size());
         $display("** can_message_frame_decoder: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [7:0] lo;
      cfg = '{protocol_version: 8'd1, node_id_low: 8'd1, node_id_high: 8'd254,
              broadcast_node: 8'd255, command_std_id: 11'd256, response_std_id: 11'd257,
              event_std_id: 11'd258, text_std_id: 11'd259};
      for (int i = 0; i < 4; i++) status_tally[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_until_drained();
         case (phase)
            0: ; // reset values stay in place
            1: begin
               csr_write(REG_PROTOCOL_VERSION, 11'd255);
               csr_write(REG_NODE_ID_LOW, 11'd0);
               csr_write(REG_NODE_ID_HIGH, 11'd255);
               csr_write(REG_BROADCAST_NODE, 11'd0);
               csr_write(REG_COMMAND_STD_ID, 11'd0);
               csr_write(REG_RESPONSE_STD_ID, 11'd2047);
               csr_write(REG_EVENT_STD_ID, 11'd1);
               csr_write(REG_TEXT_STD_ID, 11'd1024);
            end
            2: begin
               // empty node range, only broadcast passes; response shadowed by command
               csr_write(REG_PROTOCOL_VERSION, 11'd0);
               csr_write(REG_NODE_ID_LOW, 11'd200);
               csr_write(REG_NODE_ID_HIGH, 11'd100);
               csr_write(REG_BROADCAST_NODE, 11'd128);
               csr_write(REG_COMMAND_STD_ID, 11'h155);
               csr_write(REG_RESPONSE_STD_ID, 11'h155);
               csr_write(REG_EVENT_STD_ID, 11'h2AA);
               csr_write(REG_TEXT_STD_ID, 11'h7FE);
            end
            3: begin
               csr_write(REG_PROTOCOL_VERSION, 11'h5A);
               csr_write(REG_NODE_ID_LOW, 11'h10);
               csr_write(REG_NODE_ID_HIGH, 11'h10);
               csr_write(REG_BROADCAST_NODE, 11'h10);
               csr_write(REG_COMMAND_STD_ID, 11'h400);
               csr_write(REG_RESPONSE_STD_ID, 11'h3FF);
               csr_write(REG_EVENT_STD_ID, 11'h001);
               csr_write(REG_TEXT_STD_ID, 11'h7FF);
            end
            default: begin
               lo = 8'($urandom_range(128));
               csr_write(REG_PROTOCOL_VERSION, 11'($urandom_range(255)));
               csr_write(REG_NODE_ID_LOW, {3'd0, lo});
               csr_write(REG_NODE_ID_HIGH, 11'($urandom_range(255, lo)));
               csr_write(REG_BROADCAST_NODE, 11'($urandom_range(255)));
               csr_write(REG_COMMAND_STD_ID, 11'($urandom));
               csr_write(REG_RESPONSE_STD_ID, 11'($urandom));
               csr_write(REG_EVENT_STD_ID, 11'($urandom));
               csr_write(REG_TEXT_STD_ID, 11'($urandom));
            end
         endcase

         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 83; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 83; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase

         if (phase == 0) begin
            // byte 7 first in each data word, byte 0 last
            frames_to_send.push_back(make_frame(1'b1, 1'b0, 29'h100, 4'd8,
                                                64'hA5_33_22_11_7C_02_01_01));
            frames_to_send.push_back(make_frame(1'b0, 1'b1, 29'h101, 4'd8,
                                                64'hA5_33_22_11_7C_02_01_01));
            frames_to_send.push_back(make_frame(1'b1, 1'b1, 29'h1FFFFFFF, 4'd15, '1));
            frames_to_send.push_back(std_frame(29'h0, 4'd8, '0));
            frames_to_send.push_back(std_frame(29'h100100, 4'd8, 64'hA5_33_22_11_7C_02_01_01));
            frames_to_send.push_back(std_frame(29'h1FFFFFFF, 4'd8, 64'hA5_33_22_11_7C_02_01_01));
            frames_to_send.push_back(std_frame(29'h100, 4'd8, 64'hA5_33_22_11_7C_02_01_01));
            frames_to_send.push_back(std_frame(29'h101, 4'd15, 64'h00_FF_FF_FF_FF_FE_FE_01));
            frames_to_send.push_back(std_frame(29'h102, 4'd8, 64'hFF_FF_FF_FF_FF_FF_FF_01));
            frames_to_send.push_back(std_frame(29'h100, 4'd7, 64'hA5_33_22_11_7C_02_01_01));
            frames_to_send.push_back(std_frame(29'h100, 4'd8, 64'hA5_33_22_11_7C_02_01_02));
            frames_to_send.push_back(std_frame(29'h101, 4'd8, 64'hA5_33_22_11_7C_02_00_01));
            frames_to_send.push_back(std_frame(29'h102, 4'd8, 64'hA5_33_22_11_7C_00_01_01));
            frames_to_send.push_back(std_frame(29'h103, 4'd6, 64'hFF_00_41_01_42_06_05_01));
            frames_to_send.push_back(std_frame(29'h103, 4'd8, 64'h20_7E_20_03_09_FF_FE_01));
            frames_to_send.push_back(std_frame(29'h103, 4'd12, 64'h7A_61_5A_03_00_FF_FF_01));
            frames_to_send.push_back(std_frame(29'h103, 4'd4, 64'h00_00_41_01_42_06_05_01));
            frames_to_send.push_back(std_frame(29'h103, 4'd6, 64'h00_00_41_01_42_06_05_00));
            frames_to_send.push_back(std_frame(29'h103, 4'd6, 64'h00_00_41_01_42_00_05_01));
            frames_to_send.push_back(std_frame(29'h103, 4'd8, 64'h41_41_41_00_42_06_05_01));
            frames_to_send.push_back(std_frame(29'h103, 4'd15, 64'h41_41_41_04_42_06_05_01));
            frames_to_send.push_back(std_frame(29'h103, 4'd7, 64'h41_41_41_03_42_06_05_01));
            frames_to_send.push_back(std_frame(29'h103, 4'd6, 64'h41_41_1F_01_42_06_05_01));
            frames_to_send.push_back(std_frame(29'h103, 4'd8, 64'h7F_41_41_03_42_06_05_01));
            // third character is not printable but lies past the length
            frames_to_send.push_back(std_frame(29'h103, 4'd7, 64'h00_7E_20_02_42_06_05_01));
            frames_to_send.push_back(std_frame(29'h100, 4'd15, '1));
            frames_to_send.push_back(std_frame(29'h103, 4'd0, '0));
         end
         repeat (RANDOM_PER_PHASE) frames_to_send.push_back(random_frame());
      end

      wait_until_drained();
      repeat (8) @(posedge clock);
      if (expected_msgs.size() != 0) begin
         $error("%0d results never arrived", expected_msgs.size());
         mismatches++;
      end
      $display("%0d frames decoded and compared under %0d register settings",
               results_seen, NUM_PHASES);
      $display("and four idling patterns");
      $display("status mix: ok %0d, invalid %0d, ignored %0d, unsupported %0d; %0d mismatches",
               status_tally[ST_OK], status_tally[ST_INVALID], status_tally[ST_IGNORED],
               status_tally[ST_UNSUPPORTED], mismatches);
      if (mismatches == 0) begin
         $display("** can_message_frame_decoder: PASSED **");
      end else begin
         $display("** can_message_frame_decoder: FAILED **");
      end
      $finish;
   end

endmodule
